@@ hw/rtl/bcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the block change detector: word layouts of
// the input and result channels, register indexes and geometry widths.
// ----------------------------------------------------------------------------
package bcd_pkg;

  // Block position counters
  localparam int unsigned POS_BITS = 6;
  // Geometry register width (blocks_wide, blocks_high)
  localparam int unsigned GEO_W    = 7;
  // Width for the last-position compare: holds count + 1 and geometry
  localparam int unsigned CMP_W    = ((POS_BITS > GEO_W) ? POS_BITS : GEO_W) + 1;
  localparam int unsigned SCAN_W   = 3;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned FIELD_POS_W = 6;

  // Sample width, row width, groups per row, samples per group
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned ROW_W      = 128;
  localparam int unsigned GROUPS     = 4;
  localparam int unsigned GROUP_SIZE = 4;
  // Signed sum of four differences: -1020 .. 1020
  localparam int unsigned SUM_W      = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_WIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_LINE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THR  = 2'd3;

  // Reset values of the registers
  localparam logic [GEO_W-1:0]  BLOCKS_WIDE_RST = 7'd22;
  localparam logic [GEO_W-1:0]  BLOCKS_HIGH_RST = 7'd18;
  localparam logic [SCAN_W-1:0] SCAN_LINE_RST   = 3'd0;
  localparam logic [THR_W-1:0]  CHANGE_THR_RST  = 10'd24;
  // Scan lines at or above this select lower-neighbor mode
  localparam logic [SCAN_W-1:0] LOWER_MODE_LINE = 3'd4;

  typedef struct packed {
    logic [63:0] cur_top_low;
    logic [63:0] cur_top_high;
    logic [63:0] ref_top_low;
    logic [63:0] ref_top_high;
    logic [63:0] cur_bottom_low;
    logic [63:0] cur_bottom_high;
    logic [63:0] ref_bottom_low;
    logic [63:0] ref_bottom_high;
  } in_word_t;

  typedef struct packed {
    logic                   mark_northwest;
    logic                   mark_north;
    logic                   mark_northeast;
    logic                   mark_west;
    logic                   mark_middle;
    logic                   mark_east;
    logic                   mark_southwest;
    logic                   mark_south;
    logic                   mark_southeast;
    logic [FIELD_POS_W-1:0] block_col;
    logic [FIELD_POS_W-1:0] block_row;
  } out_word_t;

endpackage : bcd_pkg
`default_nettype wire

@@ hw/rtl/bcd_row_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_row_cmp
// Per-group change flags of one sample row: four groups of four samples,
// |sum(cur - ref)| compared against the change threshold.
// ----------------------------------------------------------------------------
module bcd_row_cmp import bcd_pkg::*; (
  input  wire logic [ROW_W-1:0]  cur_row,
  input  wire logic [ROW_W-1:0]  ref_row,
  input  wire logic [THR_W-1:0]  threshold,
  output logic      [GROUPS-1:0] changed
);

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic        [SUM_W-1:0] mag;
    int unsigned             idx;
    for (int g = 0; g < GROUPS; g++) begin
      sum = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        // sample 0 sits in the top byte of the row
        idx = ROW_W - SAMPLE_W * (g * GROUP_SIZE + k + 1);
        sum = sum + $signed({{(SUM_W-SAMPLE_W){1'b0}}, cur_row[idx +: SAMPLE_W]})
                  - $signed({{(SUM_W-SAMPLE_W){1'b0}}, ref_row[idx +: SAMPLE_W]});
      end
      mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      changed[g] = (mag >= {{(SUM_W-THR_W){1'b0}}, threshold});
    end
  end

endmodule : bcd_row_cmp
`default_nettype wire

@@ hw/rtl/block_change_detector_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// block_change_detector_top
// Change detection for conditional replenishment: neighbor mark mask and
// position for each macroblock.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one word per 16x16 macroblock in raster order on in_valid/in_ready:
//   16 current and 16 reference luma samples of the scan row and of the row
//   eight lines below. Each word yields exactly one result word on
//   out_valid/out_ready carrying nine neighbor marks and the block column and
//   row from internal counters.
//   Path: the input register takes the word and the result register loads
//   from it once it can advance, with the group sums and compares between
//   them.
//   Throughput: one word per cycle; in_ready follows out_ready through the
//   two stages, so the block keeps taking words while the sink takes results.
//   Stall: when out_ready is low the result register holds, the input
//   register fills and in_ready drops; nothing is lost or repeated.
//   Config: cfg_valid/cfg_ready writes register cfg_index with cfg_data;
//   cfg_ready is always high. Write only while the block is empty.
//   Reset (rst_n low, synchronous): registers return to 22 x 18 blocks,
//   scan line 0, threshold 24; counters go to block 0,0; both stages empty.
// ----------------------------------------------------------------------------
module block_change_detector_top import bcd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input words
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GEO_W-1:0]  blocks_wide_r;
  logic [GEO_W-1:0]  blocks_high_r;
  logic [SCAN_W-1:0] scan_line_r;
  logic [THR_W-1:0]  change_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_wide_r <= BLOCKS_WIDE_RST;
      blocks_high_r <= BLOCKS_HIGH_RST;
      scan_line_r   <= SCAN_LINE_RST;
      change_thr_r  <= CHANGE_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BLOCKS_WIDE: blocks_wide_r <= cfg_data[GEO_W-1:0];
        REG_BLOCKS_HIGH: blocks_high_r <= cfg_data[GEO_W-1:0];
        REG_SCAN_LINE:   scan_line_r   <= cfg_data[SCAN_W-1:0];
        REG_CHANGE_THR:  change_thr_r  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage control: input register feeds result register
  // --------------------------------------------------------------------------
  logic     s1_valid_r;
  in_word_t s1_data_r;
  logic     out_valid_r;
  out_word_t out_data_r;
  logic     out_adv;     // result register can load
  logic     s1_fire;     // word moves from input to result register
  logic     in_fire;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Group compares, top row and bottom row
  // --------------------------------------------------------------------------
  logic [GROUPS-1:0] top_chg;
  logic [GROUPS-1:0] bot_chg;

  bcd_row_cmp u_top_cmp (
    .cur_row   ({s1_data_r.cur_top_low, s1_data_r.cur_top_high}),
    .ref_row   ({s1_data_r.ref_top_low, s1_data_r.ref_top_high}),
    .threshold (change_thr_r),
    .changed   (top_chg)
  );

  bcd_row_cmp u_bot_cmp (
    .cur_row   ({s1_data_r.cur_bottom_low, s1_data_r.cur_bottom_high}),
    .ref_row   ({s1_data_r.ref_bottom_low, s1_data_r.ref_bottom_high}),
    .threshold (change_thr_r),
    .changed   (bot_chg)
  );

  // --------------------------------------------------------------------------
  // Position counters and edge flags
  // --------------------------------------------------------------------------
  logic [POS_BITS-1:0] col_count_r, col_count_nxt;
  logic [POS_BITS-1:0] row_count_r, row_count_nxt;
  logic first_col, first_row, last_col, last_row;

  assign first_col = (col_count_r == '0);
  assign first_row = (row_count_r == '0);
  // last when count + 1 reaches the geometry, or the counter is saturated
  assign last_col  = (CMP_W'(col_count_r) + CMP_W'(1) >= CMP_W'(blocks_wide_r)) ||
                     (col_count_r == '1);
  assign last_row  = (CMP_W'(row_count_r) + CMP_W'(1) >= CMP_W'(blocks_high_r)) ||
                     (row_count_r == '1);

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (s1_fire) begin
      if (last_col) begin
        col_count_nxt = '0;
        row_count_nxt = last_row ? '0 : row_count_r + POS_BITS'(1);
      end else begin
        col_count_nxt = col_count_r + POS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Mark mask
  // --------------------------------------------------------------------------
  out_word_t mark_nxt;
  logic      upper_mode;
  logic      any_top, any_bot;

  assign upper_mode = (scan_line_r < LOWER_MODE_LINE);
  assign any_top    = |top_chg;
  assign any_bot    = |bot_chg;

  always_comb begin
    mark_nxt = '0;
    if (upper_mode) begin
      mark_nxt.mark_northwest = top_chg[0] && !first_col && !first_row;
      mark_nxt.mark_north     = any_top && !first_row;
      mark_nxt.mark_northeast = top_chg[GROUPS-1] && !last_col && !first_row;
    end else begin
      mark_nxt.mark_southwest = bot_chg[0] && !first_col && !last_row;
      mark_nxt.mark_south     = any_bot && !last_row;
      mark_nxt.mark_southeast = bot_chg[GROUPS-1] && !last_col && !last_row;
    end
    mark_nxt.mark_west   = (top_chg[0] || bot_chg[0]) && !first_col;
    mark_nxt.mark_middle = any_top || any_bot;
    mark_nxt.mark_east   = (top_chg[GROUPS-1] || bot_chg[GROUPS-1]) && !last_col;
    mark_nxt.block_col   = FIELD_POS_W'(col_count_r);
    mark_nxt.block_row   = FIELD_POS_W'(row_count_r);
  end

  // --------------------------------------------------------------------------
  // Result register: hold while the sink stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= mark_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // any neighbor mark implies this block itself is marked
  a_middle_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.mark_middle ||
      !(out_data_r.mark_northwest || out_data_r.mark_north ||
        out_data_r.mark_northeast || out_data_r.mark_west ||
        out_data_r.mark_east || out_data_r.mark_southwest ||
        out_data_r.mark_south || out_data_r.mark_southeast)))
    else $error("neighbor mark without middle mark");

  // upper and lower neighbor marks never appear together
  a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !((out_data_r.mark_northwest || out_data_r.mark_north ||
                       out_data_r.mark_northeast) &&
                      (out_data_r.mark_southwest || out_data_r.mark_south ||
                       out_data_r.mark_southeast)))
    else $error("upper and lower marks both set");

  // a word waiting in the input register is never dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("input register lost a word under stall");

  // column advances by one unless in the last column
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !last_col) |=>
      (col_count_r == $past(col_count_r) + POS_BITS'(1)))
    else $error("column counter step wrong");

endmodule : block_change_detector_top
`default_nettype wire

@@ dv/block_change_detector_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_change_detector_top_tb
// Self-checking bench for the block change detector. A driver feeds macroblock
// words from a queue, a monitor predicts the neighbor marks and block position
// of every accepted word and checks each result word against them. Phases
// reprogram geometry, scan line and threshold between drained runs.
// ----------------------------------------------------------------------------
module block_change_detector_top_tb;
  import bcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_PAD   = 10;   // idle pad after the last run, to drain the two stages
  localparam int HOLD_AT     = 370;  // accepted words before the long sink hold
  localparam int HOLD_LEN    = 80;
  localparam logic [63:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCKS_WIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  block_change_detector_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow registers and block counters of the mark predictor
  // --------------------------------------------------------------------------
  logic [GEO_W-1:0]    shadow_wide = BLOCKS_WIDE_RST;
  logic [GEO_W-1:0]    shadow_high = BLOCKS_HIGH_RST;
  logic [SCAN_W-1:0]   shadow_scan = SCAN_LINE_RST;
  logic [THR_W-1:0]    shadow_thr  = CHANGE_THR_RST;
  logic [POS_BITS-1:0] col_at = '0;
  logic [POS_BITS-1:0] row_at = '0;

  in_word_t  feed_q [$];          // macroblock words waiting for the driver
  out_word_t expected_marks [$];  // predicted result words, oldest first

  int  err_count = 0;
  int  words_in = 0;
  int  cycle_count = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  // Sum of four signed sample differences of group g, compared with threshold.
  function automatic bit group_hot(input logic [127:0] cur, input logic [127:0] base,
                                   input int g);
    int sum;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      sum += int'(cur[127 - 8*(4*g + k) -: 8]) - int'(base[127 - 8*(4*g + k) -: 8]);
    end
    if (sum < 0) sum = -sum;
    return sum >= int'(shadow_thr);
  endfunction

  // Work out the mark mask and position of one accepted word, then advance
  // the raster counters the way the block does.
  task automatic predict_block(input in_word_t w);
    logic [3:0] t_hot;
    logic [3:0] b_hot;
    bit first_col, first_row, last_col, last_row;
    out_word_t e;
    for (int g = 0; g < 4; g++) begin
      t_hot[g] = group_hot({w.cur_top_low, w.cur_top_high},
                           {w.ref_top_low, w.ref_top_high}, g);
      b_hot[g] = group_hot({w.cur_bottom_low, w.cur_bottom_high},
                           {w.ref_bottom_low, w.ref_bottom_high}, g);
    end
    first_col = (col_at == '0);
    first_row = (row_at == '0);
    // The all-ones position is always last, so the counters never pass it
    last_col = (int'(col_at) + 1 >= int'(shadow_wide)) || (col_at == '1);
    last_row = (int'(row_at) + 1 >= int'(shadow_high)) || (row_at == '1);
    e = '0;
    if (shadow_scan < LOWER_MODE_LINE) begin
      e.mark_northwest = t_hot[0] && !first_col && !first_row;
      e.mark_north     = (|t_hot) && !first_row;
      e.mark_northeast = t_hot[3] && !last_col && !first_row;
    end else begin
      e.mark_southwest = b_hot[0] && !first_col && !last_row;
      e.mark_south     = (|b_hot) && !last_row;
      e.mark_southeast = b_hot[3] && !last_col && !last_row;
    end
    e.mark_west   = (t_hot[0] | b_hot[0]) && !first_col;
    e.mark_middle = |{t_hot, b_hot};
    e.mark_east   = (t_hot[3] | b_hot[3]) && !last_col;
    e.block_col   = FIELD_POS_W'(col_at);
    e.block_row   = FIELD_POS_W'(row_at);
    expected_marks.push_back(e);
    if (last_col) begin
      col_at = '0;
      row_at = last_row ? '0 : row_at + 1'b1;
    end else begin
      col_at = col_at + 1'b1;
    end
  endtask

  function automatic string show(input out_word_t r);
    return $sformatf("nw%0b n%0b ne%0b w%0b m%0b e%0b sw%0b s%0b se%0b col%0d row%0d",
                     r.mark_northwest, r.mark_north, r.mark_northeast, r.mark_west,
                     r.mark_middle, r.mark_east, r.mark_southwest, r.mark_south,
                     r.mark_southeast, r.block_col, r.block_row);
  endfunction

  task automatic flag_result(input string what, input out_word_t want, input out_word_t got);
    err_count++;
    if (err_count <= 10) $display("%s: expected %s, got %s", what, show(want), show(got));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus shaping
  // --------------------------------------------------------------------------
  // Build a word whose hot groups sum to +/-amount and whose cold groups sum
  // to zero; reference samples are random so every byte moves.
  function automatic in_word_t shaped_word(input logic [3:0] top_hot,
                                           input logic [3:0] bot_hot, input int amount);
    logic [127:0] cur_row [2];
    logic [127:0] base_row [2];
    logic [3:0] hot;
    in_word_t w;
    int d;
    int r;
    bit neg;
    for (int side = 0; side < 2; side++) begin
      hot = (side == 0) ? top_hot : bot_hot;
      for (int g = 0; g < 4; g++) begin
        neg = 1'($urandom_range(0, 1));
        for (int k = 0; k < 4; k++) begin
          d = hot[g] ? (amount / 4 + ((k < amount % 4) ? 1 : 0)) : 0;
          if (neg) d = -d;
          r = (d >= 0) ? int'($urandom_range(0, 255 - d)) : int'($urandom_range(-d, 255));
          cur_row[side][127 - 8*(4*g + k) -: 8]  = 8'(r + d);
          base_row[side][127 - 8*(4*g + k) -: 8] = 8'(r);
        end
      end
    end
    {w.cur_top_low, w.cur_top_high}       = cur_row[0];
    {w.ref_top_low, w.ref_top_high}       = base_row[0];
    {w.cur_bottom_low, w.cur_bottom_high} = cur_row[1];
    {w.ref_bottom_low, w.ref_bottom_high} = base_row[1];
    return w;
  endfunction

  // Mix: sums near the threshold, sums anywhere, and raw noise.
  function automatic in_word_t random_word(input int thr);
    in_word_t w;
    int pick;
    int near;
    pick = int'($urandom_range(0, 9));
    near = thr + int'($urandom_range(0, 6)) - 3;
    if (near < 0) near = 0;
    if (near > 1020) near = 1020;
    if (pick < 4) return shaped_word(4'($urandom), 4'($urandom), near);
    if (pick < 7) return shaped_word(4'($urandom), 4'($urandom), int'($urandom_range(0, 1020)));
    for (int i = 0; i < 16; i++) w[32*i +: 32] = $urandom;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present queued words at the falling edge, hold until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold word and valid until the handshake
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (feed_q.size() != 0) begin
      in_data  <= feed_q.pop_front();
      in_valid <= 1'b1;
      // Toggle now and then between back-to-back and gapped delivery
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      gap_left <= tx_calm ? 0 : int'($urandom_range(0, 8));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sink: stall a random count after each taken result word
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_took) begin
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : int'($urandom_range(0, 8));
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long sink hold once, mid-run, so the two stages fill and in_ready drops
  always @(negedge clk) begin
    if (!hold_done && words_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: track register writes, predict accepted words, check results
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCKS_WIDE: shadow_wide = cfg_data[GEO_W-1:0];
          REG_BLOCKS_HIGH: shadow_high = cfg_data[GEO_W-1:0];
          REG_SCAN_LINE:   shadow_scan = cfg_data[SCAN_W-1:0];
          REG_CHANGE_THR:  shadow_thr  = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_block(in_data);
        words_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_marks.size() == 0) begin
          flag_result("unexpected result word", '0, out_data);
        end else if (out_data !== expected_marks[0]) begin
          flag_result("mark mismatch", expected_marks.pop_front(), out_data);
        end else begin
          void'(expected_marks.pop_front());
        end
      end
    end
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
  end

  // Give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("block_change_detector_top_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // Wait until every queued word went in and every result came back.
  task automatic settle();
    while (feed_q.size() != 0 || in_valid || expected_marks.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers; junk in the unused upper data bits must be
  // dropped by the block.
  task automatic program_regs(input int wide_v, input int high_v, input int scan_v,
                              input int thr_v);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    put_reg(REG_BLOCKS_WIDE, {junk[CFG_DATA_W-1:GEO_W], GEO_W'(wide_v)});
    put_reg(REG_BLOCKS_HIGH, {junk[CFG_DATA_W-1:GEO_W], GEO_W'(high_v)});
    put_reg(REG_SCAN_LINE,   {junk[CFG_DATA_W-1:SCAN_W], SCAN_W'(scan_v)});
    put_reg(REG_CHANGE_THR,  THR_W'(thr_v));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int wide_v, input int high_v, input int scan_v,
                           input int thr_v, input int count);
    program_regs(wide_v, high_v, scan_v, thr_v);
    for (int i = 0; i < count; i++) feed_q.push_back(random_word(thr_v));
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words on reset settings (22 x 18, upper mode, threshold 24):
    // silence, full positive and negative swing, each group alone right at
    // the threshold on either row, one just under it, and all groups maxed.
    feed_q.push_back('0);
    feed_q.push_back({ALL_ONES, ALL_ONES, 128'h0, ALL_ONES, ALL_ONES, 128'h0});
    feed_q.push_back({128'h0, ALL_ONES, ALL_ONES, 128'h0, ALL_ONES, ALL_ONES});
    for (int g = 0; g < 4; g++) begin
      feed_q.push_back(shaped_word(4'b0001 << g, 4'b0000, 24));
      feed_q.push_back(shaped_word(4'b0000, 4'b0001 << g, 24));
    end
    feed_q.push_back(shaped_word(4'b0001, 4'b0000, 23));
    feed_q.push_back(shaped_word(4'b1111, 4'b1111, 1020));
    feed_q.push_back(shaped_word(4'b0000, 4'b0000, 0));
    for (int i = 0; i < 6; i++) feed_q.push_back(random_word(24));
    settle();

    // Random phases: single-block picture with threshold zero, largest
    // picture with an unreachable threshold, small pictures in both modes,
    // zero and oversized geometry, and geometry shrunk under the counters.
    run_phase(1,   1,   0, 0,    15);
    run_phase(64,  64,  7, 1023, 40);
    run_phase(5,   4,   3, 24,   60);
    run_phase(4,   3,   4, 100,  60);
    run_phase(0,   127, 5, 500,  30);
    run_phase(100, 0,   2, 1,    60);
    run_phase(3,   2,   6, 64,   60);
    run_phase(7,   5,   1, 200,  70);
    run_phase(22,  18,  0, 24,   40);

    repeat (DRAIN_PAD) @(posedge clk);
    if (err_count == 0 && expected_marks.size() == 0) begin
      $display("block_change_detector_top_tb OK");
    end else begin
      $display("block_change_detector_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_row_cmp.sv
hw/rtl/block_change_detector_top.sv
dv/block_change_detector_top_tb.sv
